// ===== rtl/ibhr_pkg.sv =====
`timescale 1ns / 1ps

package ibhr_pkg;

  localparam int unsigned IpW      = 32;
  localparam int unsigned MacW     = 48;
  localparam int unsigned MacLowW  = 8;
  localparam int unsigned LenW     = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [15:0]     EthertypeIpv4  = 16'h0800;
  localparam logic [7:0]      ProtoTcp       = 8'd6;
  localparam logic [LenW-1:0] EthHdrBytes    = 16'd14;
  localparam logic [LenW-1:0] EthIpHdrBytes  = 16'd34;

  typedef enum logic [1:0] {
    VERDICT_ABORT = 2'd0,
    VERDICT_PASS  = 2'd1,
    VERDICT_TX    = 2'd2
  } verdict_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CLIENT_IP     = 3'd0,
    REG_SERVER_A_IP   = 3'd1,
    REG_SERVER_B_IP   = 3'd2,
    REG_BALANCER_IP   = 3'd3,
    REG_CLIENT_MAC    = 3'd4,
    REG_SERVER_A_MAC  = 3'd5,
    REG_SERVER_B_MAC  = 3'd6,
    REG_BALANCER_MAC  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [IpW-1:0]     client_ip;
    logic [IpW-1:0]     server_a_ip;
    logic [IpW-1:0]     server_b_ip;
    logic [IpW-1:0]     balancer_ip;
    logic [MacLowW-1:0] client_mac_low;
    logic [MacLowW-1:0] server_a_mac_low;
    logic [MacLowW-1:0] server_b_mac_low;
    logic [MacLowW-1:0] balancer_mac_low;
  } cfg_t;

  typedef struct packed {
    logic [LenW-1:0] frame_length;
    logic [MacW-1:0] dest_mac;
    logic [MacW-1:0] src_mac;
    logic [15:0]     ethertype;
    logic [31:0]     ip_words_head;
    logic [31:0]     ip_words_frag;
    logic [7:0]      time_to_live;
    logic [7:0]      protocol_num;
    logic [IpW-1:0]  src_ip;
    logic [IpW-1:0]  dst_ip;
    logic            pick_second;
  } in_item_t;

  typedef struct packed {
    verdict_e        verdict;
    logic [MacW-1:0] new_dest_mac;
    logic [MacW-1:0] new_src_mac;
    logic [IpW-1:0]  new_src_ip;
    logic [IpW-1:0]  new_dst_ip;
    logic [15:0]     new_checksum;
  } out_item_t;

  // Ones' complement header checksum; the checksum word itself counts as zero.
  function automatic logic [15:0] hdr_checksum(
    input logic [31:0] head,
    input logic [31:0] frag,
    input logic [7:0]  ttl,
    input logic [7:0]  proto,
    input logic [31:0] sip,
    input logic [31:0] dip
  );
    logic [19:0] sum;
    logic [16:0] fold1;
    logic [15:0] fold2;
    sum = 20'(head[31:16]) + 20'(head[15:0]) + 20'(frag[31:16]) + 20'(frag[15:0])
        + 20'({ttl, proto}) + 20'(sip[31:16]) + 20'(sip[15:0])
        + 20'(dip[31:16]) + 20'(dip[15:0]);
    fold1 = 17'(sum[15:0]) + 17'(sum[19:16]);
    fold2 = fold1[15:0] + 16'(fold1[16]);
    return ~fold2;
  endfunction

endpackage

// ===== rtl/ibhr_intf.sv =====
`timescale 1ns / 1ps

interface ibhr_in_if;
  logic                valid;
  logic                ready;
  ibhr_pkg::in_item_t  item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface ibhr_out_if;
  logic                valid;
  logic                ready;
  ibhr_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ===== rtl/ibhr_cfg_regs.sv =====
`timescale 1ns / 1ps

module ibhr_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ibhr_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [ibhr_pkg::CfgDataW-1:0]   cfg_data_i,
  output ibhr_pkg::cfg_t                  cfg_o
);

  ibhr_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (ibhr_pkg::reg_idx_e'(cfg_idx_i))
        ibhr_pkg::REG_CLIENT_IP:     cfg_d.client_ip         = cfg_data_i;
        ibhr_pkg::REG_SERVER_A_IP:   cfg_d.server_a_ip       = cfg_data_i;
        ibhr_pkg::REG_SERVER_B_IP:   cfg_d.server_b_ip       = cfg_data_i;
        ibhr_pkg::REG_BALANCER_IP:   cfg_d.balancer_ip       = cfg_data_i;
        ibhr_pkg::REG_CLIENT_MAC:    cfg_d.client_mac_low    = cfg_data_i[7:0];
        ibhr_pkg::REG_SERVER_A_MAC:  cfg_d.server_a_mac_low  = cfg_data_i[7:0];
        ibhr_pkg::REG_SERVER_B_MAC:  cfg_d.server_b_mac_low  = cfg_data_i[7:0];
        ibhr_pkg::REG_BALANCER_MAC:  cfg_d.balancer_mac_low  = cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/ibhr_rewrite.sv =====
`timescale 1ns / 1ps

module ibhr_rewrite (
  input  ibhr_pkg::in_item_t  item_i,
  input  ibhr_pkg::cfg_t      cfg_i,
  output ibhr_pkg::out_item_t item_o
);

  logic short_eth, is_ipv4, short_ip, is_tcp, from_client, from_backend;
  logic do_abort, do_tx;
  logic [ibhr_pkg::IpW-1:0]     tx_dip;
  logic [ibhr_pkg::MacLowW-1:0] tx_dmac_low;

  assign short_eth    = item_i.frame_length < ibhr_pkg::EthHdrBytes;
  assign short_ip     = item_i.frame_length < ibhr_pkg::EthIpHdrBytes;
  assign is_ipv4      = item_i.ethertype == ibhr_pkg::EthertypeIpv4;
  assign is_tcp       = item_i.protocol_num == ibhr_pkg::ProtoTcp;
  assign from_client  = item_i.src_ip == cfg_i.client_ip;
  assign from_backend = (item_i.src_ip == cfg_i.server_a_ip) ||
                        (item_i.src_ip == cfg_i.server_b_ip);

  assign do_abort = short_eth || (is_ipv4 && short_ip);
  assign do_tx    = !do_abort && is_ipv4 && is_tcp && (from_client || from_backend);

  // client match wins when the client shares an address with a backend
  always_comb begin
    if (from_client) begin
      tx_dip      = item_i.pick_second ? cfg_i.server_b_ip : cfg_i.server_a_ip;
      tx_dmac_low = item_i.pick_second ? cfg_i.server_b_mac_low : cfg_i.server_a_mac_low;
    end else begin
      tx_dip      = cfg_i.client_ip;
      tx_dmac_low = cfg_i.client_mac_low;
    end
  end

  always_comb begin
    if (do_abort) begin
      item_o         = '0;
      item_o.verdict = ibhr_pkg::VERDICT_ABORT;
    end else if (do_tx) begin
      item_o.verdict      = ibhr_pkg::VERDICT_TX;
      item_o.new_dest_mac = {item_i.dest_mac[ibhr_pkg::MacW-1:8], tx_dmac_low};
      item_o.new_src_mac  = {item_i.src_mac[ibhr_pkg::MacW-1:8], cfg_i.balancer_mac_low};
      item_o.new_src_ip   = cfg_i.balancer_ip;
      item_o.new_dst_ip   = tx_dip;
      item_o.new_checksum = ibhr_pkg::hdr_checksum(item_i.ip_words_head,
                              item_i.ip_words_frag, item_i.time_to_live,
                              item_i.protocol_num, cfg_i.balancer_ip, tx_dip);
    end else begin
      item_o.verdict      = ibhr_pkg::VERDICT_PASS;
      item_o.new_dest_mac = item_i.dest_mac;
      item_o.new_src_mac  = item_i.src_mac;
      item_o.new_src_ip   = item_i.src_ip;
      item_o.new_dst_ip   = item_i.dst_ip;
      item_o.new_checksum = '0;
    end
  end

endmodule

// ===== rtl/ipv4_balancer_header_rewrite_top.sv =====
`timescale 1ns / 1ps

// IPv4 balancer header rewrite.
// in_i carries one parsed Ethernet/IPv4 header per item; out_o returns one
// verdict item for each: abort (short frame), pass (not IPv4/TCP or unknown
// source, fields echoed) or transmit (addresses, MAC low bytes and checksum
// rewritten). Both channels use valid/ready; an item moves when both are high.
// The eight address registers are written through cfg_we_i/cfg_idx_i/
// cfg_data_i; the user must write them only while no item is in flight;
// the block itself does not enforce it. An accepted item sits in the input
// register while compare/checksum logic feeds the result register, which
// holds the result until out_o takes it.
// Throughput: one item per cycle while out_o.ready is high; the input
// register and the result register each hold one item.
// When the receiver stalls, the result register holds its item and the input
// register still takes one more; after that in_i.ready drops until out_o
// drains.
// Reset clears both valid flags and all address registers to zero.
module ipv4_balancer_header_rewrite_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ibhr_in_if.sink                       in_i,
  ibhr_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [ibhr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ibhr_pkg::CfgDataW-1:0] cfg_data_i
);

  ibhr_pkg::cfg_t      cfg;
  ibhr_pkg::in_item_t  in_q;
  ibhr_pkg::out_item_t res_d, out_q;
  logic                in_vld_q, out_vld_q;
  logic                out_load, in_load;

  ibhr_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ibhr_rewrite u_rewrite (
    .item_i (in_q),
    .cfg_i  (cfg),
    .item_o (res_d)
  );

  assign out_load   = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || out_load;
  assign in_load    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (!out_vld_q || out_o.ready) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_q <= in_i.item;
    end
    if (out_load) begin
      out_q <= res_d;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.item  = out_q;

`ifndef SYNTHESIS
  // an item in the input register moves on whenever the result side has room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_vld_q)
    else $error("item lost between input and result register");

  // input register full and result stalled must hold off the sender
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_vld_q && !out_o.ready) |-> !in_i.ready)
    else $error("input accepted while both registers full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.verdict == ibhr_pkg::VERDICT_ABORT) |->
      (out_q.new_src_ip == '0 && out_q.new_checksum == '0 && out_q.new_dst_ip == '0))
    else $error("abort result carries nonzero fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.verdict == ibhr_pkg::VERDICT_TX) |->
      (out_q.new_src_ip == cfg.balancer_ip &&
       out_q.new_src_mac[7:0] == cfg.balancer_mac_low))
    else $error("transmit result not sourced from balancer");
`endif

endmodule
